// File: hw/rtl/chtb_pkg.sv
// Shared types and constants for the canonical Huffman table builder.
package chtb_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int NUM_SYMBOLS_DEF  = 256;

  // Fixed field widths
  localparam int FUNC_W = 2;
  localparam int LEN_IN_W = 5;
  localparam int CNT_W  = 8;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 16;
  localparam int SIZE_W = 5;
  localparam int NEXT_W = 17;

  // Stream payload layout
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  // Item kinds carried on s_tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_BEGIN  = 2'd0,
    FN_COUNT  = 2'd1,
    FN_ADD    = 2'd2,
    FN_LOOKUP = 2'd3
  } func_t;

  // One result item
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SIZE_W-1:0] size;
    logic              status;
  } res_t;

endpackage

// File: hw/rtl/canonical_huffman_table_builder_top.sv
// Top level: stream ports, result output register and the sequencer.
//
// Builds a canonical Huffman encoding table and answers lookups, one item
// at a time. A symbol add steps the generator over code lengths, walking
// the count memory one length per cycle through its single read port.
// Results sit in an output register, so a new item is taken while the
// previous result waits. Per-length counts and per-symbol sizes are
// tracked by valid bits, so begin and reset clear them at once and no
// clearing pass is needed.
module canonical_huffman_table_builder_top import chtb_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // code_length[4:0], length_count[12:5], symbol[20:13]
  input  logic [FUNC_W-1:0]    s_tuser,  // func[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // code_bits[15:0], code_size[20:16]
  output logic [0:0]           m_tuser   // status[0]
);

  logic slot_free;
  logic res_valid;
  res_t res;
  res_t out_q;

  assign slot_free = !m_tvalid || m_tready;

  chtb_ctrl #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (func_t'(s_tuser)),
    .code_length  (s_tdata[4:0]),
    .length_count (s_tdata[12:5]),
    .symbol       (s_tdata[20:13]),
    .slot_free    (slot_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {(M_TDATA_W - CODE_W - SIZE_W)'(0), out_q.size, out_q.code};
  assign m_tuser = out_q.status;

endmodule

// File: hw/rtl/chtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/chtb_ctrl.sv
// Sequencer: count memory walk, code/size store updates and lookups.
module chtb_ctrl import chtb_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  func_t               func,
  input  logic [LEN_IN_W-1:0] code_length,
  input  logic [CNT_W-1:0]    length_count,
  input  logic [SYM_W-1:0]    symbol,
  input  logic                slot_free,
  output logic                res_valid,
  output res_t                res
);

  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int CA_W  = $clog2(MAX_CODE_LEN);
  localparam int SA_W  = $clog2(NUM_SYMBOLS);
  localparam int ST_W  = CODE_W + SIZE_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LKP, ST_RES} state_t;

  state_t                 state;
  logic [LEN_W-1:0]       cur;
  logic [NEXT_W-1:0]      next_code;
  logic [MAX_CODE_LEN-1:0] cnt_vld;
  logic [NUM_SYMBOLS-1:0] sym_vld;
  logic [LEN_W-1:0]       tl;
  logic [NEXT_W-1:0]      tcode;
  logic [SYM_W-1:0]       sym_q;
  logic                   lk_hit;

  // memory ports
  logic              cnt_we;
  logic [CA_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CA_W-1:0]   cnt_raddr;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              st_we;
  logic [ST_W-1:0]   st_wdata;
  logic [ST_W-1:0]   st_rdata;

  logic              accept;
  logic              len_ok;
  logic              sym_in_ok;
  logic              sym_q_ok;
  logic [CA_W-1:0]   ci;
  logic [CNT_W-1:0]  cval;
  logic              found;
  logic              at_max;

  chtb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CODE_LEN)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  chtb_ram #(.WIDTH(ST_W), .DEPTH(NUM_SYMBOLS)) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (sym_q[SA_W-1:0]),
    .wdata (st_wdata),
    .raddr (symbol[SA_W-1:0]),
    .rdata (st_rdata)
  );

  // decode and count walk
  always_comb begin
    accept    = in_valid && (state == ST_IDLE);
    len_ok    = (code_length != '0) && (code_length <= LEN_IN_W'(MAX_CODE_LEN));
    sym_in_ok = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
    sym_q_ok  = ({1'b0, sym_q} < (SYM_W + 1)'(NUM_SYMBOLS));
    ci        = CA_W'(tl - LEN_W'(1));
    // a count never written since begin reads as zero
    cval      = cnt_vld[ci] ? cnt_rdata : '0;
    found     = (tl != '0) && (cval != '0);
    at_max    = (tl == LEN_W'(MAX_CODE_LEN));

    cnt_we    = 1'b0;
    cnt_waddr = CA_W'(code_length - LEN_IN_W'(1));
    cnt_wdata = length_count;
    cnt_raddr = CA_W'(tl);
    if (state == ST_IDLE) begin
      cnt_raddr = CA_W'(cur - LEN_W'(1));
      cnt_we    = accept && (func == FN_COUNT) && len_ok;
    end else if (state == ST_SCAN) begin
      cnt_we    = found;
      cnt_waddr = ci;
      cnt_wdata = cval - CNT_W'(1);
    end

    st_we    = (state == ST_SCAN) && found && sym_q_ok;
    st_wdata = {tcode[CODE_W-1:0], SIZE_W'(tl)};

    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_RES) && slot_free;
  end

  // state, generator and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      next_code <= '0;
      cnt_vld   <= '0;
      sym_vld   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sym_q  <= symbol;
            tl     <= cur;
            tcode  <= next_code;
            lk_hit <= sym_in_ok && sym_vld[symbol[SA_W-1:0]];
            res    <= '0;
            unique case (func)
              FN_BEGIN: begin
                cur       <= '0;
                next_code <= '0;
                cnt_vld   <= '0;
                sym_vld   <= '0;
                state     <= ST_RES;
              end
              FN_COUNT: begin
                if (len_ok) begin
                  cnt_vld[cnt_waddr] <= 1'b1;
                end
                state <= ST_RES;
              end
              FN_ADD: begin
                state <= ST_SCAN;
              end
              FN_LOOKUP: begin
                state <= ST_LKP;
              end
              default: begin
                state <= ST_RES;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (found) begin
            cur        <= tl;
            next_code  <= tcode + NEXT_W'(1);
            if (sym_q_ok) begin
              sym_vld[sym_q[SA_W-1:0]] <= 1'b1;
            end
            res.code   <= tcode[CODE_W-1:0];
            res.size   <= SIZE_W'(tl);
            res.status <= 1'b0;
            state      <= ST_RES;
          end else if (at_max) begin
            // no counted code left: nothing changes
            res.code   <= '0;
            res.size   <= '0;
            res.status <= 1'b1;
            state      <= ST_RES;
          end else begin
            tl    <= tl + LEN_W'(1);
            tcode <= {tcode[NEXT_W-2:0], 1'b0};
          end
        end
        ST_LKP: begin
          if (lk_hit) begin
            res.code <= st_rdata[ST_W-1:SIZE_W];
            res.size <= st_rdata[SIZE_W-1:0];
          end
          res.status <= 1'b0;
          state      <= ST_RES;
        end
        ST_RES: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/chtb_checker.sv
// Port-level checks on the table builder, bound to the top level.
module chtb_checker import chtb_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [0:0]           m_tuser
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one item at a time: input closes right after an accepted item
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input open right after an accepted item");

  // an ignored symbol carries no code
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[20:0] == '0))
    else $error("flagged result carries a code");

  // code size never exceeds the longest length
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:16] <= SIZE_W'(MAX_CODE_LEN)))
    else $error("code size out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind canonical_huffman_table_builder_top chtb_checker #(
  .MAX_CODE_LEN (MAX_CODE_LEN)
) u_chtb_checker (.*);

// File: bench/canonical_huffman_table_builder_top_test.sv
// Stream-level test of the canonical Huffman table builder, checked against a local table model.
`timescale 1ns / 1ps

module canonical_huffman_table_builder_top_test;
  import chtb_pkg::*;

  localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
  localparam int NUM_SYM     = NUM_SYMBOLS_DEF;
  localparam int RANDOM_OPS  = 1950;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 300;

  // One table operation as it travels on the input stream
  typedef struct {
    func_t      func;
    logic [4:0] len;
    logic [7:0] cnt;
    logic [7:0] sym;
  } table_op_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // code_length[4:0], length_count[12:5], symbol[20:13]
  logic [FUNC_W-1:0]    s_tuser = '0;   // func[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // code_bits[15:0], code_size[20:16]
  logic [0:0]           m_tuser;        // status[0]

  canonical_huffman_table_builder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  table_op_t table_ops[$];
  table_op_t op_on_bus;
  res_t      code_results_due[$];
  int        ops_made = 0;
  int        err_cnt = 0;
  int        cyc = 0;
  int        stall_cycles = 0;

  // Local copy of the table generator state
  logic [7:0]  left_cnt [1:16];
  logic [4:0]  cur_len;
  logic [16:0] next_code;
  logic [15:0] code_mem [0:255];
  logic [4:0]  size_mem [0:255];

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic clear_table_state();
    for (int l = 1; l <= MAX_LEN; l++) left_cnt[l] = '0;
    for (int s = 0; s < NUM_SYM; s++) size_mem[s] = '0;
    cur_len   = '0;
    next_code = '0;
  endtask

  // Apply one operation to the table model and return the code it yields
  task automatic huff_table_step(input table_op_t op, output res_t r);
    int          cur;
    int          target;
    logic [15:0] code;
    r = '0;
    case (op.func)
      FN_BEGIN: clear_table_state();
      FN_COUNT: begin
        if (op.len >= 1 && op.len <= MAX_LEN) left_cnt[op.len] = op.cnt;
      end
      FN_ADD: begin
        cur    = cur_len;
        target = 0;
        if (cur >= 1 && left_cnt[cur] != 0) begin
          target = cur;
        end else begin
          for (int l = cur + 1; l <= MAX_LEN; l++)
            if (target == 0 && left_cnt[l] != 0) target = l;
        end
        if (target == 0) begin
          r.status = 1'b1;
        end else begin
          // one left shift per length stepped over; 17-bit wrap
          for (int l = cur; l < target; l++) next_code = next_code << 1;
          cur_len = 5'(target);
          code    = next_code[15:0];
          if (op.sym < NUM_SYM) begin
            code_mem[op.sym] = code;
            size_mem[op.sym] = 5'(target);
          end
          next_code        = next_code + 17'd1;
          left_cnt[target] = left_cnt[target] - 8'd1;
          r.code = code;
          r.size = 5'(target);
        end
      end
      default: begin
        if (op.sym < NUM_SYM && size_mem[op.sym] != 0) begin
          r.code = code_mem[op.sym];
          r.size = size_mem[op.sym];
        end
      end
    endcase
  endtask

  function automatic void push_op(func_t f, int len, int cnt, int sym);
    table_op_t op;
    op.func = f;
    op.len  = 5'(len);
    op.cnt  = 8'(cnt);
    op.sym  = 8'(sym);
    table_ops.push_back(op);
    // counts on a length outside 1..16 change nothing
    if (!(f == FN_COUNT && (op.len == 0 || op.len > MAX_LEN))) ops_made++;
  endfunction

  // Mostly whole tables with random content, plus random noise items
  task automatic add_random_ops();
    int         avail;
    int         n;
    int         total;
    int         adds;
    logic [7:0] added[$];
    while (ops_made < RANDOM_OPS + 25) begin
      if ($urandom_range(0, 99) < 15) begin
        push_op(func_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        push_op(FN_BEGIN, $urandom_range(0, 31), $urandom_range(0, 255),
                $urandom_range(0, 255));
        avail = 1;
        total = 0;
        added.delete();
        for (int l = 1; l <= MAX_LEN; l++) begin
          avail = avail * 2;
          if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 255);
          else n = $urandom_range(0, (avail < 3) ? avail : 3);
          if (avail > n) avail = avail - n;
          else avail = 0;
          if (n != 0 || $urandom_range(0, 3) == 0) begin
            push_op(FN_COUNT, l, n, $urandom_range(0, 255));
            total += n;
          end
        end
        adds = ((total > 24) ? 24 : total) + $urandom_range(0, 2);
        for (int k = 0; k < adds; k++) begin
          n = $urandom_range(0, 255);
          push_op(FN_ADD, $urandom_range(0, 31), $urandom_range(0, 255), n);
          added.push_back(8'(n));
          if ($urandom_range(0, 5) == 0)
            push_op(FN_LOOKUP, $urandom_range(0, 31), $urandom_range(0, 255),
                    added[$urandom_range(0, added.size() - 1)]);
        end
        n = $urandom_range(2, 8);
        for (int k = 0; k < n; k++) begin
          if (added.size() > 0 && $urandom_range(0, 1) == 1)
            push_op(FN_LOOKUP, 0, 0, added[$urandom_range(0, added.size() - 1)]);
          else
            push_op(FN_LOOKUP, 0, 0, $urandom_range(0, 255));
        end
      end
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    clear_table_state();

    // lookup and add with nothing loaded after reset
    push_op(FN_LOOKUP, 0, 0, 0);
    push_op(FN_ADD, 0, 0, 5);
    push_op(FN_BEGIN, 0, 0, 0);
    // counts on lengths out of range are dropped
    push_op(FN_COUNT, 0, 255, 0);
    push_op(FN_COUNT, 31, 255, 255);
    push_op(FN_COUNT, 4, 0, 0);
    push_op(FN_COUNT, 2, 1, 0);
    push_op(FN_COUNT, 3, 2, 0);
    // first add steps over length 1
    push_op(FN_ADD, 0, 0, 0);
    push_op(FN_ADD, 0, 0, 255);
    // rewrite of the current length count, used at once
    push_op(FN_COUNT, 3, 1, 0);
    push_op(FN_ADD, 0, 0, 128);
    // count for a length already passed stays unused
    push_op(FN_COUNT, 1, 2, 0);
    push_op(FN_COUNT, 16, 2, 0);
    push_op(FN_ADD, 0, 0, 7);
    push_op(FN_ADD, 0, 0, 7);      // duplicate overwrites
    push_op(FN_ADD, 0, 0, 9);      // no code left
    push_op(FN_LOOKUP, 0, 0, 7);
    push_op(FN_LOOKUP, 0, 0, 255);
    push_op(FN_LOOKUP, 0, 0, 1);   // codeless symbol
    // counts that break Kraft: the long code loses its top bit
    push_op(FN_BEGIN, 0, 0, 0);
    push_op(FN_COUNT, 1, 3, 0);
    push_op(FN_COUNT, 16, 1, 0);
    for (int s = 10; s < 14; s++) push_op(FN_ADD, 0, 0, s);
    push_op(FN_LOOKUP, 0, 0, 13);

    add_random_ops();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (table_ops.size() != 0 || s_tvalid || code_results_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("canonical_huffman_table_builder_top_test: clean");
    end else begin
      $display("canonical_huffman_table_builder_top_test: errors");
    end
    $finish;
  end

  // Cycle count and watchdog on accepted items
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("canonical_huffman_table_builder_top_test: errors");
          $finish;
        end
      end
    end
  end

  // Input driver: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    res_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        huff_table_step(op_on_bus, r);
        code_results_due.push_back(r);
      end
      if (!s_tvalid || s_tready) begin
        if (table_ops.size() != 0 &&
            ((cyc >= 2000 && cyc < 5000) || $urandom_range(0, 99) >= 19)) begin
          op_on_bus = table_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, op_on_bus.sym, op_on_bus.cnt, op_on_bus.len};
          s_tuser  <= op_on_bus.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each result item, with one long hold-off
  always @(posedge clk) begin
    static int results_seen = 0;
    static int hold_left = 0;
    res_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (code_results_due.size() == 0) begin
          $display("%0t: unexpected result code %h size %0d status %0d", $time,
                   m_tdata[15:0], m_tdata[20:16], m_tuser[0]);
          err_cnt++;
        end else begin
          exp_r = code_results_due.pop_front();
          if (m_tdata[15:0] !== exp_r.code) begin
            $display("%0t: code_bits expected %h got %h", $time, exp_r.code, m_tdata[15:0]);
            err_cnt++;
          end
          if (m_tdata[20:16] !== exp_r.size) begin
            $display("%0t: code_size expected %0d got %0d", $time, exp_r.size,
                     m_tdata[20:16]);
            err_cnt++;
          end
          if (m_tuser[0] !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status, m_tuser[0]);
            err_cnt++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (cyc >= 2000 && cyc < 5000) || $urandom_range(0, 99) >= 19;
      end
    end
  end

endmodule
